### sv/sprle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprle_pkg
// Types, constants and the code-at-head decoder shared by the subpicture
// run-length code decoder.
// ----------------------------------------------------------------------------
package sprle_pkg;

    // Bit window: up to 17 leftover bits plus one new byte, oldest bit at MSB
    localparam int WinW     = 25;
    localparam int CntW     = 5;
    localparam int ByteW    = 8;
    localparam int MaxRecs  = 3;

    // 2-bit code thresholds
    localparam logic [3:0]  TwoLim1 = 4'd4;
    localparam logic [7:0]  TwoLim2 = 8'd16;
    localparam logic [11:0] TwoLim3 = 12'h040;

    // 8-bit code run offsets
    localparam logic [7:0] ShortRunBase = 8'd2;
    localparam logic [7:0] LongRunBase  = 8'd9;

    // Code lengths
    localparam logic [CntW-1:0] LenNib1   = 5'd4;
    localparam logic [CntW-1:0] LenNib2   = 5'd8;
    localparam logic [CntW-1:0] LenNib3   = 5'd12;
    localparam logic [CntW-1:0] LenNib4   = 5'd16;
    localparam logic [CntW-1:0] LenHdr    = 5'd2;
    localparam logic [CntW-1:0] LenNarrow = 5'd4;   // header + 2 color bits
    localparam logic [CntW-1:0] LenWide   = 5'd10;  // header + 8 color bits
    localparam logic [CntW-1:0] LenShort  = 5'd4;   // flag + 3 bits
    localparam logic [CntW-1:0] LenLong   = 5'd8;   // flag + 7 bits

    // Status codes
    localparam logic StatRun   = 1'b0;
    localparam logic StatTrunc = 1'b1;

    // One result record
    typedef struct packed {
        logic [7:0] color;
        logic [7:0] run;
        logic       eol;
        logic       status;
    } t_rec;

    // Records caused by one input byte
    typedef struct packed {
        t_rec [MaxRecs-1:0] recs;
        logic [1:0]         cnt;
    } t_bnd;

    // Decode result for the code at the head of the window
    typedef struct packed {
        logic            ok;
        logic [CntW-1:0] len;
        t_rec            rec;
    } t_dec;

    localparam t_rec TruncRec = '{color: 8'd0, run: 8'd0, eol: 1'b0, status: StatTrunc};

    // Decode one code from a left-aligned window holding cnt valid bits
    function automatic t_dec decode_head(input logic [WinW-1:0] win,
                                         input logic [CntW-1:0] cnt,
                                         input logic            mode8);
        t_dec            d;
        logic [15:0]     v;
        logic [CntW-1:0] len;
        logic [CntW-1:0] pos;
        logic [7:0]      rem;
        logic [6:0]      n;
        d   = '0;
        v   = '0;
        len = '0;
        pos = '0;
        rem = '0;
        n   = '0;
        if (!mode8) begin
            // nibble code: extend while the value stays below the limit
            if (win[24:21] >= TwoLim1) begin
                v   = {12'd0, win[24:21]};
                len = LenNib1;
            end else if (win[24:17] >= TwoLim2) begin
                v   = {8'd0, win[24:17]};
                len = LenNib2;
            end else if (win[24:13] >= TwoLim3) begin
                v   = {4'd0, win[24:13]};
                len = LenNib3;
            end else begin
                v   = win[24:9];
                len = LenNib4;
            end
            d.rec.color  = {6'd0, v[1:0]};
            d.rec.eol    = (v < 16'd4);
            d.rec.run    = d.rec.eol ? 8'd0 : v[9:2];
            d.rec.status = StatRun;
            d.len        = len;
            d.ok         = (cnt >= len);
        end else begin
            // flag code: run flag, wide flag, color, optional run field
            pos = win[23] ? LenWide : LenNarrow;
            rem = win[23] ? win[14:7] : win[20:13];
            d.rec.color  = win[23] ? win[22:15] : {6'd0, win[22:21]};
            d.rec.status = StatRun;
            d.rec.eol    = 1'b0;
            if (!win[24]) begin
                len       = pos;
                d.rec.run = 8'd1;
            end else if (rem[7]) begin
                n   = rem[6:0];
                len = pos + LenLong;
                if (n == 7'd0) begin
                    d.rec.eol = 1'b1;
                    d.rec.run = 8'd0;
                end else begin
                    d.rec.run = {1'b0, n} + LongRunBase;
                end
            end else begin
                len       = pos + LenShort;
                d.rec.run = {5'd0, rem[6:4]} + ShortRunBase;
            end
            d.len = len;
            d.ok  = (cnt >= LenHdr) && (cnt >= len);
        end
        return d;
    endfunction

endpackage

### sv/subpicture_rle_code_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subpicture_rle_code_decoder_unit
// Subpicture run-length code decoder: bytes in MSB first, run records out.
// ----------------------------------------------------------------------------
// A byte's records are registered as one group and sent from the queue head.
// Throughput: one byte per cycle and one record per cycle; a byte yields 0..3
//   records, held in a two-entry record-group queue that sets input ready.
// Reset (synchronous, active low) clears the bit window, the pending count,
//   the mode register and the queue. A mode write also empties the window.
module subpicture_rle_code_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write: bit 0 = eight_bit_mode
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // coded byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] stream_byte
    input  logic        i_s_tlast,   // end_of_data
    // run records
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] pixel_color, [15:8] run_length,
                                     // [16] to_line_end, [23:17] zero
    output logic        o_m_tuser,   // status
    output logic        o_m_tlast    // last_of_item
);

    logic [sprle_pkg::WinW-1:0] r_win, n_win;
    logic [sprle_pkg::CntW-1:0] r_cnt, n_cnt;
    logic                       r_mode;
    sprle_pkg::t_bnd            r_b0, r_b1, n_bnd;
    logic                       r_v0, r_v1;
    logic [1:0]                 r_idx;

    logic                       in_acc, out_acc, out_last, pop_done, push;
    logic [sprle_pkg::WinW-1:0] w0, w1, w2;
    logic [sprle_pkg::CntW-1:0] c0, c1, c2;
    sprle_pkg::t_dec            d1, d2;
    logic                       trunc;
    logic [1:0]                 nrun;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_v1;
    assign in_acc      = i_s_tvalid && o_s_tready;

    // merge the new byte under the pending bits and decode up to two codes
    always_comb begin
        w0 = r_win | ({i_s_tdata, {(sprle_pkg::WinW - sprle_pkg::ByteW){1'b0}}} >> r_cnt);
        c0 = r_cnt + sprle_pkg::CntW'(sprle_pkg::ByteW);
        d1 = sprle_pkg::decode_head(w0, c0, r_mode);
        w1 = d1.ok ? (w0 << d1.len) : w0;
        c1 = d1.ok ? (c0 - d1.len) : c0;
        d2 = sprle_pkg::decode_head(w1, c1, r_mode);
        d2.ok = d2.ok && d1.ok;
        w2 = d2.ok ? (w1 << d2.len) : w1;
        c2 = d2.ok ? (c1 - d2.len) : c1;
        trunc = i_s_tlast && (c2 != '0);
        nrun  = {1'b0, d1.ok} + {1'b0, d2.ok};
        n_bnd.recs[0] = d1.ok ? d1.rec : sprle_pkg::TruncRec;
        n_bnd.recs[1] = d2.ok ? d2.rec : sprle_pkg::TruncRec;
        n_bnd.recs[2] = sprle_pkg::TruncRec;
        n_bnd.cnt     = nrun + {1'b0, trunc};
        n_win = i_s_tlast ? '0 : w2;
        n_cnt = i_s_tlast ? '0 : c2;
    end

    assign push = in_acc && (n_bnd.cnt != 2'd0);

    // mode register and bit window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_win  <= '0;
            r_cnt  <= '0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
            r_win  <= '0;
            r_cnt  <= '0;
        end else if (in_acc) begin
            r_win <= n_win;
            r_cnt <= n_cnt;
        end
    end

    // output side: head record group, one record per transfer
    assign o_m_tvalid = r_v0;
    assign out_acc    = r_v0 && i_m_tready;
    assign out_last   = (r_idx == (r_b0.cnt - 2'd1));
    assign pop_done   = out_acc && out_last;

    assign o_m_tdata  = {7'd0, r_b0.recs[r_idx].eol, r_b0.recs[r_idx].run,
                         r_b0.recs[r_idx].color};
    assign o_m_tuser  = r_b0.recs[r_idx].status;
    assign o_m_tlast  = out_last;

    // two-entry record-group queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_idx <= 2'd0;
        end else begin
            if (pop_done) begin
                r_idx <= 2'd0;
            end else if (out_acc) begin
                r_idx <= r_idx + 2'd1;
            end
            if (pop_done) begin
                if (r_v1) begin
                    r_v0 <= 1'b1;
                    r_v1 <= 1'b0;
                end else begin
                    r_v0 <= push;
                end
            end else if (push) begin
                if (!r_v0) begin
                    r_v0 <= 1'b1;
                end else begin
                    r_v1 <= 1'b1;
                end
            end
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (pop_done) begin
            if (r_v1) begin
                r_b0 <= r_b1;
            end else if (push) begin
                r_b0 <= n_bnd;
            end
        end else if (push) begin
            if (!r_v0) begin
                r_b0 <= n_bnd;
            end else begin
                r_b1 <= n_bnd;
            end
        end
    end

    // checks
    a_tail_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("second queue entry valid while head empty");

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 |-> (r_idx < r_b0.cnt))
        else $error("record index beyond head group");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 5'd17)
        else $error("pending bit count out of range");

    a_eod_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_tlast) |=> (r_cnt == '0))
        else $error("window not cleared after end of data");

endmodule

### tb/subpicture_rle_code_decoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subpicture_rle_code_decoder_unit_test
// Self-checking bench for the subpicture run-length code decoder. A short
// table of hand-made bytes covers both code modes, line ends, the longest
// runs, truncation at end of data and mode writes that drop pending bits.
// Random frames of well-formed codes follow, mixed with noise bytes and
// frames cut short, while both stream sides stall at random. Every run
// record is checked against typed rows or a bit-accurate bench decoder model.
// ----------------------------------------------------------------------------
module subpicture_rle_code_decoder_unit_test;

    localparam int ClkPeriod    = 4;
    localparam int ResetCycles  = 10;
    localparam int SettleCycles = 4;
    localparam int RandBytes    = 352;
    localparam int PhaseBytes   = 48;
    localparam int CycleLimit   = 100000;
    localparam int MaxReports   = 100;

    localparam logic ModeNibble = 1'b0;
    localparam logic ModeByte   = 1'b1;

    // one run record as seen on the master side
    typedef struct packed {
        logic [7:0] color;
        logic [7:0] run;
        logic       eol;
        logic       status;
        logic       last;
    } t_run_rec;

    typedef enum logic {ROW_BYTE, ROW_MODE} t_row_kind;

    // directed row: a byte or a mode write, with optional hand-typed records
    typedef struct packed {
        t_row_kind        kind;
        logic [7:0]       val;
        logic             eod;
        logic             typed;
        logic [1:0]       n_typed;
        t_run_rec [0:2]   recs;
    } t_row;

    localparam t_run_rec NoRec    = '0;
    localparam t_run_rec EolC0L   = '{8'd0, 8'd0, 1'b1, sprle_pkg::StatRun, 1'b1};
    localparam t_run_rec C3R3     = '{8'd3, 8'd3, 1'b0, sprle_pkg::StatRun, 1'b0};
    localparam t_run_rec C3R3L    = '{8'd3, 8'd3, 1'b0, sprle_pkg::StatRun, 1'b1};
    localparam t_run_rec WideFF   = '{8'hFF, 8'd1, 1'b0, sprle_pkg::StatRun, 1'b0};
    localparam t_run_rec Pix0     = '{8'd0, 8'd1, 1'b0, sprle_pkg::StatRun, 1'b0};
    localparam t_run_rec Pix0L    = '{8'd0, 8'd1, 1'b0, sprle_pkg::StatRun, 1'b1};
    localparam t_run_rec TruncL   = '{8'd0, 8'd0, 1'b0, sprle_pkg::StatTrunc, 1'b1};

    localparam int PlanRows = 25;

    t_row plan [0:PlanRows-1] = '{
        // 2-bit code, starting from reset
        '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 2'd1, '{EolC0L, NoRec, NoRec}},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 2'd2, '{C3R3, C3R3L, NoRec}},
        '{ROW_BYTE, 8'h47, 1'b0, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'h12, 1'b1, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'h01, 1'b1, 1'b1, 2'd1, '{TruncL, NoRec, NoRec}},
        '{ROW_BYTE, 8'h04, 1'b0, 1'b1, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'h3F, 1'b0, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'h03, 1'b0, 1'b1, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'hF0, 1'b1, 1'b1, 2'd2, '{C3R3, TruncL, NoRec}},
        // 8-bit code
        '{ROW_MODE, 8'h01, 1'b0, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'h7F, 1'b0, 1'b1, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'hC0, 1'b0, 1'b1, 2'd2, '{WideFF, Pix0L, NoRec}},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 2'd3, '{Pix0, Pix0, TruncL}},
        '{ROW_BYTE, 8'h98, 1'b0, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'hEA, 1'b0, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'hBF, 1'b0, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'hC0, 1'b1, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'hB7, 1'b0, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'h80, 1'b1, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'h7F, 1'b0, 1'b1, 2'd0, '{NoRec, NoRec, NoRec}},
        // back to 2-bit code; the pending byte must be dropped
        '{ROW_MODE, 8'h00, 1'b0, 1'b0, 2'd0, '{NoRec, NoRec, NoRec}},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 2'd2, '{C3R3, C3R3L, NoRec}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // decoder model state
    logic [24:0] win_bits = '0;
    int unsigned win_count = 0;
    logic        mode8 = ModeNibble;

    t_run_rec expected_runs [$];
    bit       frame_bits [$];
    int       fail_count = 0;
    int       bytes_sent = 0;
    int       cycle_count = 0;
    bit       tx_idle = 1'b1;
    bit       rx_idle = 1'b1;

    subpicture_rle_code_decoder_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    // n bits starting at offset off from the oldest pending bit
    function automatic logic [31:0] peek_bits(input int unsigned off, input int unsigned n);
        logic [31:0] w;
        w = 32'(win_bits) >> (win_count - off - n);
        return w & ((32'd1 << n) - 32'd1);
    endfunction

    // length of the complete code at the head of the window, 0 if incomplete
    function automatic int unsigned head_code(output t_run_rec r);
        logic [31:0] v;
        int unsigned len;
        int unsigned cbits;
        logic        has_run;
        r = '0;
        r.status = sprle_pkg::StatRun;
        if (mode8 == ModeNibble) begin
            if (win_count < 4) return 0;
            v = peek_bits(0, 4);
            len = 4;
            if (v < 4) begin
                if (win_count < 8) return 0;
                v = peek_bits(0, 8);
                len = 8;
                if (v < 16) begin
                    if (win_count < 12) return 0;
                    v = peek_bits(0, 12);
                    len = 12;
                    if (v < 'h40) begin
                        if (win_count < 16) return 0;
                        v = peek_bits(0, 16);
                        len = 16;
                    end
                end
            end
            r.color = {6'd0, v[1:0]};
            r.eol   = (v < 4);
            r.run   = r.eol ? 8'd0 : v[9:2];
            return len;
        end
        // flag code: run flag, wide flag, color, optional run field
        if (win_count < 2) return 0;
        has_run = (peek_bits(0, 1) != 32'd0);
        cbits   = (peek_bits(1, 1) != 32'd0) ? 8 : 2;
        len     = 2;
        if (win_count < len + cbits) return 0;
        r.color = 8'(peek_bits(len, cbits));
        len += cbits;
        if (!has_run) begin
            r.run = 8'd1;
            return len;
        end
        if (win_count < len + 1) return 0;
        if (peek_bits(len, 1) != 32'd0) begin
            len += 1;
            if (win_count < len + 7) return 0;
            v = peek_bits(len, 7);
            len += 7;
            r.eol = (v == 0);
            r.run = r.eol ? 8'd0 : v[7:0] + 8'd9;
        end else begin
            len += 1;
            if (win_count < len + 3) return 0;
            v = peek_bits(len, 3);
            len += 3;
            r.run = v[7:0] + 8'd2;
        end
        return len;
    endfunction

    // shift one byte into the window and collect the records it completes
    function automatic void decode_byte(input logic [7:0] b, input logic eod,
                                        output t_run_rec [0:2] recs, output int nrec);
        int unsigned len;
        t_run_rec    r;
        int          i;
        recs = '0;
        nrec = 0;
        win_bits = {win_bits[16:0], b};
        win_count += 8;
        for (i = 0; i < 2; i++) begin
            len = head_code(r);
            if (len == 0) break;
            win_count -= len;
            win_bits &= 25'((32'd1 << win_count) - 32'd1);
            recs[nrec] = r;
            nrec++;
        end
        if (eod) begin
            if (win_count != 0) begin
                recs[nrec] = TruncL;
                nrec++;
            end
            win_bits  = '0;
            win_count = 0;
        end
        if (nrec > 0) recs[nrec-1].last = 1'b1;
    endfunction

    // record fields as text for reports
    function automatic string rec_text(input t_run_rec r);
        return $sformatf("color=%0d run=%0d eol=%0d status=%0d last=%0d",
                         r.color, r.run, r.eol, r.status, r.last);
    endfunction

    function automatic void append_field(input logic [15:0] v, input int w);
        int i;
        for (i = w - 1; i >= 0; i--) frame_bits.push_back(v[i]);
    endfunction

    // one well-formed code of the current mode with random content
    function automatic void add_code();
        logic wide;
        logic has_run;
        logic long_sel;
        if (mode8 == ModeNibble) begin
            case ($urandom_range(1, 5))
                1: append_field(16'($urandom_range(4, 15)), 4);
                2: append_field(16'($urandom_range(16, 63)), 8);
                3: append_field(16'($urandom_range(64, 255)), 12);
                4: append_field(16'($urandom_range(4, 1023)), 16);
                default: append_field(16'($urandom_range(0, 3)), 16);
            endcase
        end else begin
            has_run = 1'($urandom_range(0, 1));
            wide    = 1'($urandom_range(0, 1));
            append_field(16'(has_run), 1);
            append_field(16'(wide), 1);
            append_field(16'($urandom_range(0, 255)), wide ? 8 : 2);
            if (has_run) begin
                long_sel = 1'($urandom_range(0, 1));
                append_field(16'(long_sel), 1);
                if (long_sel)
                    append_field(($urandom_range(0, 3) == 0) ? 16'd0
                                 : 16'($urandom_range(1, 127)), 7);
                else
                    append_field(16'($urandom_range(0, 7)), 3);
            end
        end
    endfunction

    // one byte transfer; valid stays up when the next byte follows at once
    task automatic push_byte(input logic [7:0] b, input logic eod, input logic typed,
                             input logic [1:0] n_typed, input t_run_rec [0:2] typed_recs);
        t_run_rec [0:2] recs;
        int             nrec;
        int             gap;
        int             i;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eod;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        decode_byte(b, eod, recs, nrec);
        if (typed) begin
            recs = typed_recs;
            nrec = int'(n_typed);
        end
        for (i = 0; i < nrec; i++) expected_runs.push_back(recs[i]);
        bytes_sent++;
        @(negedge clk);
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // stop sending, wait for all records, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        mode8     = m;
        win_bits  = '0;
        win_count = 0;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random frame: mostly valid codes, sometimes cut short or pure noise
    task automatic send_frame();
        t_run_rec [0:2] none;
        logic [7:0]     b;
        int             nbytes;
        int             i;
        int             j;
        none = '0;
        if ($urandom_range(0, 4) == 0) begin
            nbytes = $urandom_range(1, 6);
            repeat (nbytes)
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                          1'b0, 2'd0, none);
            return;
        end
        frame_bits.delete();
        repeat ($urandom_range(1, 8)) add_code();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 7))
                if (frame_bits.size() > 0) void'(frame_bits.pop_back());
        end
        while (frame_bits.size() % 8 != 0) frame_bits.push_back(1'($urandom_range(0, 1)));
        nbytes = frame_bits.size() / 8;
        for (i = 0; i < nbytes; i++) begin
            for (j = 0; j < 8; j++) b[7-j] = frame_bits[8*i+j];
            push_byte(b, (i == nbytes - 1) && ($urandom_range(0, 3) != 0), 1'b0, 2'd0, none);
        end
    endtask

    // record sink with random stalls, checks each transfer
    initial begin
        t_run_rec got;
        t_run_rec want;
        int       gap;
        wait (rst_n);
        @(negedge clk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[16], m_tuser, m_tlast};
            if (expected_runs.size() == 0) begin
                fail_count++;
                if (fail_count <= MaxReports)
                    $display("%0t: unexpected record %s", $time, rec_text(got));
            end else begin
                want = expected_runs.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MaxReports)
                        $display("%0t: record mismatch: expected %s, got %s",
                                 $time, rec_text(want), rec_text(got));
                end
            end
            @(negedge clk);
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // main sequence
    initial begin
        int phase;
        int phase_end;
        int frame;
        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_MODE) begin
                settle();
                write_mode(plan[i].val[0]);
            end else begin
                push_byte(plan[i].val, plan[i].eod, plan[i].typed, plan[i].n_typed,
                          plan[i].recs);
            end
        end
        settle();

        // random phases, each with its own mode and stall pattern
        bytes_sent = 0;
        phase = 0;
        while (bytes_sent < RandBytes) begin
            if (phase == 0)
                write_mode(ModeNibble);
            else if (phase == 1)
                write_mode(ModeByte);
            else
                write_mode(1'($urandom_range(0, 1)));
            tx_idle   = (phase % 3 != 2);
            rx_idle   = (phase % 4 != 3);
            phase_end = bytes_sent + PhaseBytes;
            frame     = 0;
            while (bytes_sent < phase_end && bytes_sent < RandBytes) begin
                send_frame();
                frame++;
                // sender holds off until the sink has drained
                if (frame % 7 == 3) settle();
            end
            settle();
            phase++;
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
sv/sprle_pkg.sv
sv/subpicture_rle_code_decoder_unit.sv
tb/subpicture_rle_code_decoder_unit_test.sv
